@@ rtl/htfd_pkg.sv @@
package htfd_pkg;

  localparam int RAW_W   = 20;
  localparam int HUM_W   = 14;
  localparam int TEMP_W  = 15;
  localparam int POS_W   = 3;
  localparam int PAY_W   = 40;   // bytes 1..5; byte 0 only feeds the CRC

  localparam logic [7:0]       CRC_POLY    = 8'h31;
  localparam logic [7:0]       CRC_INIT    = 8'hFF;
  localparam logic [7:0]       NO_CHECKSUM = 8'hFF;
  localparam logic [POS_W-1:0] LAST_POS    = 3'd6;

  localparam logic [RAW_W:0]   RAW_MAX     = 21'd1048575;
  localparam logic [13:0]      HUM_SCALE   = 14'd10000;
  localparam logic [14:0]      TEMP_SCALE  = 15'd20000;
  localparam logic [HUM_W-1:0] HUM_MAX     = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;
  localparam logic signed [15:0] TEMP_MIN    = -16'sd4000;
  localparam logic signed [15:0] TEMP_MAX    = 16'sd8500;

  typedef struct packed {
    logic             frame_ok;
    logic             checksum_present;
    logic [RAW_W-1:0] raw_humidity;
    logic [RAW_W-1:0] raw_temperature;
  } frame_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/htfd_assembler.sv @@
module htfd_assembler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                frm_valid,
  input  logic                frm_ready,
  output htfd_pkg::frame_t    frm
);
  import htfd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic             frm_valid_r, frm_valid_nxt;
  frame_t           frm_r, frm_nxt;

  logic [POS_W-1:0] pos_eff;
  logic [7:0]       crc_eff;
  logic [PAY_W-1:0] pay_eff;
  logic             accept;
  logic             present;

  assign in_ready  = !frm_valid_r || frm_ready;
  assign accept    = in_valid && in_ready;
  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

  // A start flag throws away whatever partial frame is held.
  assign pos_eff = frame_start ? '0 : pos_r;
  assign crc_eff = frame_start ? CRC_INIT : crc_r;
  assign pay_eff = frame_start ? '0 : pay_r;
  assign present = (rx_byte != NO_CHECKSUM);

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    pay_nxt       = pay_r;
    frm_nxt       = frm_r;
    frm_valid_nxt = frm_valid_r && !frm_ready;
    if (accept) begin
      if (pos_eff < LAST_POS) begin
        crc_nxt = crc8_step(crc_eff, rx_byte);
        pay_nxt = {pay_eff[PAY_W-9:0], rx_byte};
        pos_nxt = pos_eff + 1'b1;
      end else begin
        frm_nxt.checksum_present = present;
        frm_nxt.frame_ok         = !present || (crc_eff == rx_byte);
        frm_nxt.raw_humidity     = pay_eff[2*RAW_W-1:RAW_W];
        frm_nxt.raw_temperature  = pay_eff[RAW_W-1:0];
        frm_valid_nxt            = 1'b1;
        pos_nxt                  = '0;
        crc_nxt                  = CRC_INIT;
        pay_nxt                  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      pay_r       <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      pay_r       <= pay_nxt;
      frm_valid_r <= frm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_r <= frm_nxt;
  end

endmodule

@@ rtl/htfd_scaler.sv @@
module htfd_scaler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              frm_valid,
  output logic                              frm_ready,
  input  htfd_pkg::frame_t                  frm,
  output logic                              out_valid,
  input  logic                              out_ready,
  output htfd_pkg::frame_t                  out_frm,
  output logic [htfd_pkg::HUM_W-1:0]        humidity_centi,
  output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi
);
  import htfd_pkg::*;

  logic                     out_valid_r, out_valid_nxt;
  frame_t                   frm_out_r;
  logic [HUM_W-1:0]         hum_r, hum_nxt;
  logic signed [TEMP_W-1:0] temp_r, temp_nxt;

  logic [33:0]        prod_h;
  logic [34:0]        prod_t;
  logic [RAW_W:0]     rem_h, rem_t;
  logic [HUM_W-1:0]   q_h;
  logic [14:0]        q_t;
  logic signed [15:0] temp_w;
  logic               load;

  assign frm_ready = !out_valid_r || out_ready;
  assign load      = frm_valid && frm_ready;

  // Division by 2^20-1: N = q0*2^20 + L = q0*(2^20-1) + (q0 + L), and
  // q0 + L stays below twice the divisor, so one correction step suffices.
  always_comb begin
    prod_h = frm.raw_humidity * HUM_SCALE;
    rem_h  = {1'b0, prod_h[RAW_W-1:0]} + {7'd0, prod_h[33:RAW_W]};
    q_h    = prod_h[33:RAW_W] + ((rem_h >= RAW_MAX) ? 14'd1 : 14'd0);
    hum_nxt = (q_h > HUM_MAX) ? HUM_MAX : q_h;

    prod_t = frm.raw_temperature * TEMP_SCALE;
    rem_t  = {1'b0, prod_t[RAW_W-1:0]} + {6'd0, prod_t[34:RAW_W]};
    q_t    = prod_t[34:RAW_W] + ((rem_t >= RAW_MAX) ? 15'd1 : 15'd0);
    temp_w = $signed({1'b0, q_t}) - TEMP_OFFSET;
    if (temp_w < TEMP_MIN) begin
      temp_nxt = TEMP_MIN[TEMP_W-1:0];
    end else if (temp_w > TEMP_MAX) begin
      temp_nxt = TEMP_MAX[TEMP_W-1:0];
    end else begin
      temp_nxt = temp_w[TEMP_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frm_out_r <= frm;
      hum_r     <= hum_nxt;
      temp_r    <= temp_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frm           = frm_out_r;
  assign humidity_centi    = hum_r;
  assign temperature_centi = temp_r;

endmodule

@@ rtl/humidity_temp_frame_decoder_core.sv @@
// Channel | Direction | Beat contents
// in_     | slave     | tdata[7:0] rx_byte; tuser[0] frame_start
// out_    | master    | tdata: raw_humidity, raw_temperature, humidity_centi,
//         |           |        temperature_centi; tuser: frame_ok, checksum_present
//
// One byte beat is taken per clock while in_tready is high. Six of every seven
// beats only update the running CRC and the payload shift register; the seventh
// produces one result. The edge that accepts the seventh byte loads the frame
// register. The scaling logic sits between that register and the output
// register, which loads the scaled result once it is free to take it.
// Reset (rst_n low, synchronous) empties both stages and rewinds the frame to
// byte 0 with the CRC at 0xFF. A stall on out_ holds the output register; once
// the frame register also holds a result, in_tready drops for every byte until
// the output register frees up.
module humidity_temp_frame_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [19:0] raw_humidity, [39:20] raw_temperature,
                                  // [53:40] humidity_centi, [68:54] temperature_centi,
                                  // [71:69] zero
  output logic [1:0]  out_tuser   // [0] frame_ok, [1] checksum_present
);
  import htfd_pkg::*;

  frame_t                   frm;
  frame_t                   out_frm;
  logic                     frm_valid;
  logic                     frm_ready;
  logic [HUM_W-1:0]         humidity_centi;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic                     in_rdy_raw;

  // Byte assembly, CRC check and the frame register.
  htfd_assembler u_asm (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_rdy_raw),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser[0]),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  // Scaling to hundredths and the output register.
  htfd_scaler u_scl (
    .clk               (clk),
    .rst_n             (rst_n),
    .frm_valid         (frm_valid),
    .frm_ready         (frm_ready),
    .frm               (frm),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_frm           (out_frm),
    .humidity_centi    (humidity_centi),
    .temperature_centi (temperature_centi)
  );

  assign in_tready = in_rdy_raw;

  assign out_tdata = {3'b000, temperature_centi, humidity_centi,
                      out_frm.raw_temperature, out_frm.raw_humidity};
  assign out_tuser = {out_frm.checksum_present, out_frm.frame_ok};

endmodule

@@ rtl/htfd_checker.sv @@
module htfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A result waiting on a stalled sink holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A checksum can only mismatch when one was sent.
  a_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[0] || out_tuser[1])
    else $error("mismatch flagged without checksum");

  a_hum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[53:40] <= 14'd10000)
    else $error("humidity out of range");

  a_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[68:54]) >= -15'sd4000) &&
                   ($signed(out_tdata[68:54]) <= 15'sd8500))
    else $error("temperature out of range");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
